### sv/spibd_pkg.sv
package spibd_pkg;

   localparam int FreqWidth  = 28;
   localparam int PselWidth  = 3;
   localparam int RselWidth  = 4;
   localparam int BaudWidth  = 7;
   localparam int LaneMax    = 8;
   localparam int RecipWidth = 29;
   localparam int ProdWidth  = FreqWidth + RecipWidth;

   typedef logic [FreqWidth-1:0] freq_type;

   localparam freq_type CoreClockReset = 28'd48000000;

   // reciprocals exact for every 28-bit core clock
   localparam logic [RecipWidth-1:0] Recip3 = 29'd357913942;
   localparam logic [RecipWidth-1:0] Recip5 = 29'd429496730;
   localparam logic [RecipWidth-1:0] Recip7 = 29'd306783379;
   localparam int Recip3Shift  = 30;
   localparam int Recip57Shift = 31;

   // quotients of the reset core clock, one per prescaler code
   localparam freq_type QuotReset [LaneMax] = '{
      FreqWidth'(CoreClockReset / 1), FreqWidth'(CoreClockReset / 2),
      FreqWidth'(CoreClockReset / 3), FreqWidth'(CoreClockReset / 4),
      FreqWidth'(CoreClockReset / 5), FreqWidth'(CoreClockReset / 6),
      FreqWidth'(CoreClockReset / 7), FreqWidth'(CoreClockReset / 8)
   };

   typedef struct packed {
      logic [PselWidth-1:0] psel;
      logic [RselWidth-1:0] rsel;
      freq_type             err;
   } cand_type;

endpackage

### sv/spi_baud_divider_search.sv
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | req_target_freq
// rsp     | out       | rsp_valid / rsp_stall  | rsp_prescale_sel, rsp_rate_sel, rsp_baud_value
// csr     | in        | csr_valid / csr_ready  | csr_core_clock_hz
//
// one request per cycle while req_stall is low; each passes the input register, rate search and error
// registers, then the best-prescaler tree into the result register.
// a core clock write loads the per-prescaler quotients at its own edge, by shifts and
// reciprocal multiplies; csr_ready is always high. reset is synchronous and loads them too.
// rsp_stall holds the result register and backs up the stages; req_stall only when all are full.
module spi_baud_divider_search #(
   parameter int PRESCALE_COUNT = 8,
   parameter int RATE_CODE_MAX  = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [spibd_pkg::FreqWidth-1:0] req_target_freq,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [spibd_pkg::PselWidth-1:0] rsp_prescale_sel,
   output logic [spibd_pkg::RselWidth-1:0] rsp_rate_sel,
   output logic [spibd_pkg::BaudWidth-1:0] rsp_baud_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spibd_pkg::FreqWidth-1:0] csr_core_clock_hz
);
   import spibd_pkg::*;

   localparam logic [RselWidth-1:0] RateMax = RselWidth'(RATE_CODE_MAX);

   // quotients
   logic [ProdWidth-1:0] prod3, prod5, prod7;
   freq_type             q_ff   [PRESCALE_COUNT];
   freq_type             q_in   [LaneMax];

   // pipeline
   logic     v0_ff, v1_ff, v2_ff, vo_ff;
   logic     en0, en1, en2, eno;
   freq_type t0_ff, t1_ff;
   logic [RselWidth-1:0] s1_ff [PRESCALE_COUNT];
   logic [RselWidth-1:0] s1_in [PRESCALE_COUNT];
   freq_type             sh1_ff [PRESCALE_COUNT];
   freq_type             sh1_in [PRESCALE_COUNT];
   logic [RselWidth-1:0] s2_ff [PRESCALE_COUNT];
   freq_type             e2_ff [PRESCALE_COUNT];
   freq_type             e2_in [PRESCALE_COUNT];
   cand_type             lvl0 [LaneMax];
   cand_type             lvl1 [LaneMax/2];
   cand_type             lvl2 [LaneMax/4];
   cand_type             best;
   logic [PselWidth-1:0] psel_ff;
   logic [RselWidth-1:0] rsel_ff;
   logic [BaudWidth-1:0] baud_ff;

   function automatic cand_type pick(input cand_type a, input cand_type b);
      // lower prescaler wins a tie
      return (b.err < a.err) ? b : a;
   endfunction

   // ---------------- quotients ----------------
   always_comb begin
      prod3   = ProdWidth'(csr_core_clock_hz) * ProdWidth'(Recip3);
      prod5   = ProdWidth'(csr_core_clock_hz) * ProdWidth'(Recip5);
      prod7   = ProdWidth'(csr_core_clock_hz) * ProdWidth'(Recip7);
      q_in[0] = csr_core_clock_hz;
      q_in[1] = csr_core_clock_hz >> 1;
      q_in[2] = FreqWidth'(prod3 >> Recip3Shift);
      q_in[3] = csr_core_clock_hz >> 2;
      q_in[4] = FreqWidth'(prod5 >> Recip57Shift);
      // divide by six is divide by three, then halve
      q_in[5] = FreqWidth'(prod3 >> (Recip3Shift + 1));
      q_in[6] = FreqWidth'(prod7 >> Recip57Shift);
      q_in[7] = csr_core_clock_hz >> 3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PRESCALE_COUNT; p++) begin
            q_ff[p] <= QuotReset[p];
         end
      end else if (csr_valid && csr_ready) begin
         for (int p = 0; p < PRESCALE_COUNT; p++) begin
            q_ff[p] <= q_in[p];
         end
      end
   end

   assign csr_ready = 1'b1;

   // ---------------- pipeline control ----------------
   assign eno       = !vo_ff || !rsp_stall;
   assign en2       = !v2_ff || eno;
   assign en1       = !v1_ff || en2;
   assign en0       = !v0_ff || en1;
   assign req_stall = !en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en0) begin
            v0_ff <= req_valid && !req_stall;
         end
         if (en1) begin
            v1_ff <= v0_ff;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (eno) begin
            vo_ff <= v2_ff;
         end
      end
   end

   // ---------------- rate search per prescaler ----------------
   always_comb begin
      for (int p = 0; p < PRESCALE_COUNT; p++) begin
         s1_in[p]  = RateMax;
         sh1_in[p] = q_ff[p] >> (RATE_CODE_MAX + 1);
         // descending so the smallest passing rate code is kept
         for (int s = RATE_CODE_MAX - 1; s >= 0; s--) begin
            if ((q_ff[p] >> (s + 1)) <= t0_ff) begin
               s1_in[p]  = RselWidth'(s);
               sh1_in[p] = q_ff[p] >> (s + 1);
            end
         end
      end
   end

   always_comb begin
      for (int p = 0; p < PRESCALE_COUNT; p++) begin
         e2_in[p] = (t1_ff >= sh1_ff[p]) ? (t1_ff - sh1_ff[p]) : (sh1_ff[p] - t1_ff);
      end
   end

   // ---------------- best prescaler tree ----------------
   always_comb begin
      for (int i = 0; i < LaneMax; i++) begin
         lvl0[i].psel = PselWidth'(i);
         lvl0[i].rsel = '0;
         lvl0[i].err  = '1;
      end
      for (int p = 0; p < PRESCALE_COUNT; p++) begin
         lvl0[p].rsel = s2_ff[p];
         lvl0[p].err  = e2_ff[p];
      end
      for (int i = 0; i < LaneMax/2; i++) begin
         lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
      end
      for (int i = 0; i < LaneMax/4; i++) begin
         lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
      end
      best = pick(lvl2[0], lvl2[1]);
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         t0_ff <= req_target_freq;
      end
      if (en1) begin
         t1_ff <= t0_ff;
         for (int p = 0; p < PRESCALE_COUNT; p++) begin
            s1_ff[p]  <= s1_in[p];
            sh1_ff[p] <= sh1_in[p];
         end
      end
      if (en2) begin
         for (int p = 0; p < PRESCALE_COUNT; p++) begin
            s2_ff[p] <= s1_ff[p];
            e2_ff[p] <= e2_in[p];
         end
      end
      if (eno) begin
         psel_ff <= best.psel;
         rsel_ff <= best.rsel;
         baud_ff <= {best.psel, best.rsel};
      end
   end

   assign rsp_valid        = vo_ff;
   assign rsp_prescale_sel = psel_ff;
   assign rsp_rate_sel     = rsel_ff;
   assign rsp_baud_value   = baud_ff;

`ifndef ASSERT_OFF
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while the pipe had room");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_baud_value))
      else $error("stalled result changed");

   a_rate_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rate_sel <= RateMax)
      else $error("rate code beyond its maximum");

   a_psel_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_prescale_sel) < PRESCALE_COUNT)
      else $error("prescaler code beyond the prescaler count");

   a_baud_packed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_baud_value == {rsp_prescale_sel, rsp_rate_sel})
      else $error("packed byte disagrees with its codes");
`endif

endmodule

### dv/tb_spi_baud_divider_search.sv
module tb_spi_baud_divider_search;
   import spibd_pkg::*;

   localparam int PrescaleCount = 8;
   localparam int RateCodeMax   = 9;
   localparam int PipeLatency   = 4;
   localparam int HoldOffCycles = 300;
   localparam int PhaseRequests = 150;
   localparam int MaxReported   = 10;
   // slowest case: ~1250 requests with long gaps and stalls, two hold-offs, eight reloads
   localparam int CycleLimit    = 400000;

   typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_type;

   typedef struct packed {
      freq_type             target;
      logic [PselWidth-1:0] psel;
      logic [RselWidth-1:0] rsel;
      logic [BaudWidth-1:0] baud;
   } divider_choice_type;

   localparam freq_type DirectedTargets [21] = '{
      28'd0, 28'd1, 28'd2, 28'hFFFFFFF, 28'd200000000, 28'd24000000, 28'd18000000,
      28'd12000000, 28'd8000000, 28'd6000001, 28'd3000000, 28'd1000000, 28'd46875,
      28'd46874, 28'd5859, 28'd1000, 28'd100, 28'h8000000, 28'h5555555, 28'hAAAAAAA,
      28'd23999999
   };

   class divider_scoreboard;
      freq_type           core_clock;
      divider_choice_type pending_choices[$];
      int unsigned        mismatches;

      function new();
         core_clock = CoreClockReset;
         mismatches = 0;
      endfunction

      // closest divider setting for one target at the current core clock
      function divider_choice_type best_divider(freq_type target);
         freq_type             quot, shifted, err, best_err;
         logic [RselWidth-1:0] rate, best_rate;
         logic [PselWidth-1:0] best_lane;
         divider_choice_type   choice;
         best_err  = '0;
         best_rate = '0;
         best_lane = '0;
         for (int lane = 0; lane < PrescaleCount; lane++) begin
            quot = core_clock / freq_type'(lane + 1);
            rate = '0;
            while (((quot >> (rate + 1)) > target) && (rate < RateCodeMax))
               rate++;
            shifted = quot >> (rate + 1);
            err = (target >= shifted) ? target - shifted : shifted - target;
            // strict compare, so the lowest prescaler keeps a tie
            if (lane == 0 || err < best_err) begin
               best_lane = PselWidth'(lane);
               best_rate = rate;
               best_err  = err;
            end
         end
         choice.target = target;
         choice.psel   = best_lane;
         choice.rsel   = best_rate;
         choice.baud   = {best_lane, best_rate};
         return choice;
      endfunction

      function void note_target(freq_type target);
         pending_choices.push_back(best_divider(target));
      endfunction

      function void check_choice(logic [PselWidth-1:0] psel, logic [RselWidth-1:0] rsel,
                                 logic [BaudWidth-1:0] baud);
         divider_choice_type want;
         if (pending_choices.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("%0t: result with no request pending: p=%0d s=%0d baud=%0d",
                        $time, psel, rsel, baud);
            return;
         end
         want = pending_choices.pop_front();
         if (psel !== want.psel || rsel !== want.rsel || baud !== want.baud) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("%0t: target %0d core %0d: want %0d/%0d/%0d, got %0d/%0d/%0d",
                        $time, want.target, core_clock, want.psel, want.rsel, want.baud,
                        psel, rsel, baud);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [FreqWidth-1:0] req_target_freq;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PselWidth-1:0] rsp_prescale_sel;
   logic [RselWidth-1:0] rsp_rate_sel;
   logic [BaudWidth-1:0] rsp_baud_value;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [FreqWidth-1:0] csr_core_clock_hz;

   divider_scoreboard scoreboard;
   int                send_idle_pct   = 0;
   int                stall_pct       = 0;
   int                hold_off_cycles = 0;
   int                cycle_count;

   spi_baud_divider_search u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_target_freq   (req_target_freq),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_prescale_sel  (rsp_prescale_sel),
      .rsp_rate_sel      (rsp_rate_sel),
      .rsp_baud_value    (rsp_baud_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_core_clock_hz (csr_core_clock_hz)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IdleNone: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IdleSender: begin
            send_idle_pct = 76;
            stall_pct     = 0;
         end
         IdleReceiver: begin
            send_idle_pct = 0;
            stall_pct     = 76;
         end
         default: begin
            send_idle_pct = 22;
            stall_pct     = 22;
         end
      endcase
   endtask

   task automatic offer_request(input freq_type target);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_target_freq <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scoreboard.note_target(target);
   endtask

   // lower valid, then wait for every pending result and for the pipe to empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending_choices.size() != 0);
      repeat (PipeLatency + 4) @(posedge clock);
   endtask

   task automatic write_core_clock(input freq_type core_hz);
      csr_valid         <= 1'b1;
      csr_core_clock_hz <= core_hz;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      scoreboard.core_clock = core_hz;
   endtask

   // mix of full-range, log-spread and near-candidate targets
   function automatic freq_type pick_target(input freq_type core_hz);
      int unsigned span, lane, rate;
      longint      near;
      case ($urandom_range(0, 9))
         0, 1: return freq_type'($urandom);
         2, 3, 4, 5: begin
            span = $urandom_range(0, FreqWidth);
            return freq_type'(longint'($urandom) & ((64'd1 << span) - 1));
         end
         default: begin
            lane = $urandom_range(0, PrescaleCount - 1);
            rate = $urandom_range(0, RateCodeMax + 1);
            near = longint'((core_hz / freq_type'(lane + 1)) >> rate)
                   + longint'($urandom_range(0, 4)) - 2;
            if (near < 0)
               near = 0;
            return freq_type'(near);
         end
      endcase
   endfunction

   task automatic run_phase(input freq_type core_hz, input idle_mode_type mode,
                            input int hold_at, input int pause_at);
      wait_drained();
      write_core_clock(core_hz);
      set_idle_mode(mode);
      for (int i = 0; i < PhaseRequests; i++) begin
         if (i == hold_at)
            hold_off_cycles = HoldOffCycles;
         if (i == pause_at)
            wait_drained();
         offer_request(pick_target(scoreboard.core_clock));
      end
   endtask

   // result side
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            scoreboard.check_choice(rsp_prescale_sel, rsp_rate_sel, rsp_baud_value);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[spi_baud_divider_search] ERROR");
      $finish;
   end

   initial begin
      int failures;
      scoreboard = new();
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_target_freq   <= '0;
      csr_valid         <= 1'b0;
      csr_core_clock_hz <= '0;
      set_idle_mode(IdleNone);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset core clock first
      foreach (DirectedTargets[k])
         offer_request(DirectedTargets[k]);

      run_phase(28'd48000000, IdleSender, -1, 60);
      run_phase(28'd200000000, IdleReceiver, -1, -1);
      run_phase(28'd1, IdleBoth, -1, -1);
      // zero core clock: every candidate ties
      run_phase(28'd0, IdleNone, 40, -1);
      run_phase(28'hFFFFFFF, IdleSender, -1, 80);
      run_phase(freq_type'($urandom_range(1, 200000000)), IdleReceiver, -1, -1);
      run_phase(freq_type'($urandom), IdleBoth, -1, -1);
      run_phase(28'd48000000, IdleNone, 70, -1);

      wait_drained();
      failures = scoreboard.mismatches + scoreboard.pending_choices.size();
      if (failures == 0)
         $display("[spi_baud_divider_search] OK");
      else
         $display("[spi_baud_divider_search] ERROR");
      $finish;
   end

endmodule

### filelist.f
sv/spibd_pkg.sv
sv/spi_baud_divider_search.sv
dv/tb_spi_baud_divider_search.sv
